FILE: rtl/usbtx_pkg.sv
// Shared constants for the low-speed USB device transmit packet layer.
// Used by usbtx_crc and usb_low_speed_device_tx_mac; no dependencies.
package usbtx_pkg;

  // Input item kinds (tuser of the input channel).
  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_SETUP  = 3'd1;
  localparam logic [2:0] KIND_OUT    = 3'd2;
  localparam logic [2:0] KIND_DATA0  = 3'd3;
  localparam logic [2:0] KIND_DATA1  = 3'd4;
  localparam logic [2:0] KIND_ACK    = 3'd5;
  localparam logic [2:0] KIND_SEND   = 3'd6;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  // Result item kinds (tuser of the output channel).
  localparam logic [2:0] RES_BYTE    = 3'd0;
  localparam logic [2:0] RES_ENDED   = 3'd1;
  localparam logic [2:0] RES_STARTED = 3'd2;
  localparam logic [2:0] RES_BUSY    = 3'd3;
  localparam logic [2:0] RES_CONFIG  = 3'd4;

  localparam logic [7:0] PID_DATA0 = 8'hC3;
  localparam logic [7:0] PID_DATA1 = 8'h4B;

  localparam logic [7:0] REQ_TYPE_STD    = 8'h00;
  localparam logic [7:0] REQ_ASSIGN_ADDR = 8'd5;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'd9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int MAX_PACKET = 8;

endpackage

FILE: rtl/usbtx_crc.sv
// Reflected CRC-16 accumulator, one byte per cycle while en is high.
// Depends on usbtx_pkg for the polynomial and initial value.
module usbtx_crc
  import usbtx_pkg::*;
(
  input  logic        clk,
  input  logic        init,
  input  logic        en,
  input  logic [7:0]  data,
  output logic [15:0] crc
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    for (int i = 0; i < 8; i++) begin
      if (crc_nxt[0] ^ data[i]) begin
        crc_nxt = (crc_nxt >> 1) ^ CRC_POLY;
      end else begin
        crc_nxt = crc_nxt >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      crc_r <= CRC_INIT;
    end else if (en) begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

FILE: rtl/usb_low_speed_device_tx_mac.sv
// Low-speed USB device transmit packet layer: transmit store, toggles, packets.
// The result sequencer emits one byte or notice per cycle while the output is
// not stalled by out_tready; one item is worked at a time. Reset (synchronous,
// rst_n low) clears toggles, address and transfer cursor; the transmit store is
// not cleared. Depends on usbtx_pkg, usbtx_crc.
module usb_low_speed_device_tx_mac
  import usbtx_pkg::*;
#(
  parameter int STORE_DEPTH    = 256,
  parameter int ENDPOINT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // endpoint[3:0], buffer_index[11:4], byte_in[19:12], send_length[28:20],
  // request_type[36:29], request_code[44:37], request_value[60:45],
  // request_length[76:61], response_length[85:77], zero fill above
  input  logic [87:0] in_tdata,
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // byte_out[7:0], endpoint_out[11:8], status[12], number[28:13], zero fill above
  output logic [31:0] out_tdata,
  output logic [2:0]  out_tuser,  // result_kind[2:0]
  output logic        out_tlast
);

  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CFG, ST_END, ST_BUILD, ST_DATA, ST_CRC_LO, ST_CRC_HI, ST_PID, ST_NOTE
  } state_t;

  typedef enum logic [1:0] {PH_NONE, PH_SETUP, PH_OUT} phase_t;

  // Input fields.
  logic [3:0]  f_ep;
  logic [7:0]  f_bidx, f_byte, f_rtype, f_rcode;
  logic [8:0]  f_slen, f_resp;
  logic [15:0] f_rval, f_rlen;

  assign f_ep    = in_tdata[3:0];
  assign f_bidx  = in_tdata[11:4];
  assign f_byte  = in_tdata[19:12];
  assign f_slen  = in_tdata[28:20];
  assign f_rtype = in_tdata[36:29];
  assign f_rcode = in_tdata[44:37];
  assign f_rval  = in_tdata[60:45];
  assign f_rlen  = in_tdata[76:61];
  assign f_resp  = in_tdata[85:77];

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [ENDPOINT_COUNT-1:0] tog_r, tog_nxt;
  logic [3:0]  tok_ep_r, tok_ep_nxt, snd_ep_r, snd_ep_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic signed [17:0] left_r, left_nxt, allow_r, allow_nxt;
  logic [15:0] off_r, off_nxt;
  logic        active_r, active_nxt, pend_r, pend_nxt;
  logic [3:0]  end_ep_r, end_ep_nxt;
  logic        end_st_r, end_st_nxt, end_last_r, end_last_nxt;
  logic        end_again_r, end_again_nxt, end_build_r, end_build_nxt;
  logic        start_r, start_nxt;
  logic [2:0]  note_kind_r, note_kind_nxt;
  logic [3:0]  note_ep_r, note_ep_nxt;
  logic [15:0] note_num_r, note_num_nxt;
  logic [3:0]  cnt_r, cnt_nxt, plen_r, plen_nxt;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [2:0]  out_user_r;
  logic        out_last_r;

  // Transmit store.
  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic        crc_init, crc_en;
  logic [15:0] crc;

  logic        accept, emit_ok, emit_v;
  logic [2:0]  e_kind;
  logic [7:0]  e_byte;
  logic [3:0]  e_ep;
  logic        e_st, e_last;
  logic [15:0] e_num;

  logic [15:0] tok_mask;
  logic        tok_hit;
  logic signed [17:0] left_sub, allow_sub;
  logic [3:0]  n_pkt;
  logic [15:0] resp_len;

  assign accept  = in_tvalid && in_tready;
  assign emit_ok = !out_valid_r || out_tready;

  function automatic logic [15:0] ep_mask(input logic [3:0] ep);
    logic [15:0] m;
    m = 16'd1 << ep;
    if ({1'b0, ep} >= 5'(ENDPOINT_COUNT)) begin
      m = '0;
    end
    return m;
  endfunction

  assign tok_mask = ep_mask(tok_ep_r);
  assign tok_hit  = |(tog_r & tok_mask[ENDPOINT_COUNT-1:0]);

  assign left_sub  = left_r - 18'(MAX_PACKET);
  assign allow_sub = allow_r - 18'(MAX_PACKET);

  always_comb begin
    n_pkt = (left_r > 18'(MAX_PACKET)) ? 4'(MAX_PACKET) : left_r[3:0];
    if (allow_r < $signed({14'd0, n_pkt})) begin
      n_pkt = allow_r[3:0];
    end
  end

  // Standard requests that assign the address or choose a configuration return nothing.
  always_comb begin
    resp_len = {7'd0, f_resp};
    if (f_rtype == REQ_TYPE_STD &&
        (f_rcode == REQ_ASSIGN_ADDR || f_rcode == REQ_SET_CONFIG)) begin
      resp_len = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    tog_nxt       = tog_r;
    tok_ep_nxt    = tok_ep_r;
    snd_ep_nxt    = snd_ep_r;
    addr_nxt      = addr_r;
    left_nxt      = left_r;
    allow_nxt     = allow_r;
    off_nxt       = off_r;
    active_nxt    = active_r;
    pend_nxt      = pend_r;
    end_ep_nxt    = end_ep_r;
    end_st_nxt    = end_st_r;
    end_last_nxt  = end_last_r;
    end_again_nxt = end_again_r;
    end_build_nxt = end_build_r;
    start_nxt     = start_r;
    note_kind_nxt = note_kind_r;
    note_ep_nxt   = note_ep_r;
    note_num_nxt  = note_num_r;
    cnt_nxt       = cnt_r;
    plen_nxt      = plen_r;
    wr_en         = 1'b0;
    crc_init      = 1'b0;
    crc_en        = 1'b0;
    emit_v        = 1'b0;
    e_kind        = RES_BYTE;
    e_byte        = '0;
    e_ep          = snd_ep_r;
    e_st          = 1'b0;
    e_num         = '0;
    e_last        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Every ended notice reports the endpoint the cursor belonged to.
          end_ep_nxt    = snd_ep_r;
          end_again_nxt = 1'b0;
          end_build_nxt = 1'b0;
          start_nxt     = 1'b0;
          priority case (in_tuser)
            KIND_LOAD: begin
              wr_en = 1'b1;
            end
            KIND_SETUP: begin
              phase_nxt    = PH_SETUP;
              tok_ep_nxt   = f_ep;
              end_st_nxt   = 1'b1;
              end_last_nxt = 1'b1;
              left_nxt     = '0;
              allow_nxt    = '0;
              off_nxt      = '0;
              active_nxt   = 1'b0;
              pend_nxt     = 1'b0;
              state_nxt    = ST_END;
            end
            KIND_OUT: begin
              tok_ep_nxt = f_ep;
              phase_nxt  = PH_OUT;
            end
            KIND_DATA0, KIND_DATA1: begin
              if (in_tuser == KIND_DATA0) begin
                tog_nxt = tog_r | tok_mask[ENDPOINT_COUNT-1:0];
              end else begin
                tog_nxt = tog_r & ~tok_mask[ENDPOINT_COUNT-1:0];
              end
              if (phase_r == PH_SETUP) begin
                if (f_rtype == REQ_TYPE_STD && f_rcode == REQ_ASSIGN_ADDR) begin
                  addr_nxt = f_rval[6:0];
                end
                note_kind_nxt = RES_CONFIG;
                note_ep_nxt   = tok_ep_r;
                note_num_nxt  = f_rval;
                end_st_nxt    = 1'b1;
                end_last_nxt  = 1'b0;
                end_build_nxt = 1'b1;
                snd_ep_nxt    = tok_ep_r;
                left_nxt      = $signed({2'd0, resp_len});
                allow_nxt     = $signed({2'd0, f_rlen});
                off_nxt       = '0;
                active_nxt    = 1'b1;
                pend_nxt      = 1'b0;
                phase_nxt     = PH_NONE;
                if (f_rtype == REQ_TYPE_STD && f_rcode == REQ_SET_CONFIG) begin
                  state_nxt = ST_CFG;
                end else begin
                  state_nxt = ST_END;
                end
              end
            end
            KIND_ACK: begin
              tog_nxt   = tog_r ^ tok_mask[ENDPOINT_COUNT-1:0];
              pend_nxt  = 1'b0;
              end_st_nxt = 1'b0;
              if (left_sub < 0 || allow_sub < 0) begin
                // Overrun: the cursor is cleared twice, so two ended notices.
                left_nxt      = '0;
                allow_nxt     = '0;
                off_nxt       = '0;
                active_nxt    = 1'b0;
                end_again_nxt = 1'b1;
                end_last_nxt  = 1'b0;
                if (phase_r != PH_SETUP) begin
                  phase_nxt = PH_NONE;
                end
                state_nxt = ST_END;
              end else if (active_r) begin
                left_nxt  = left_sub;
                allow_nxt = allow_sub;
                off_nxt   = off_r + 16'(MAX_PACKET);
                state_nxt = ST_BUILD;
              end else begin
                left_nxt     = '0;
                allow_nxt    = '0;
                off_nxt      = '0;
                end_last_nxt = 1'b1;
                state_nxt    = ST_END;
              end
            end
            KIND_SEND: begin
              note_ep_nxt = f_ep;
              if (active_r || addr_r == 7'd0 || pend_r) begin
                note_kind_nxt = RES_BUSY;
                note_num_nxt  = '0;
                state_nxt     = ST_NOTE;
              end else begin
                note_kind_nxt = RES_STARTED;
                note_num_nxt  = {7'd0, f_slen};
                end_st_nxt    = 1'b1;
                end_last_nxt  = 1'b0;
                end_build_nxt = 1'b1;
                start_nxt     = 1'b1;
                snd_ep_nxt    = f_ep;
                left_nxt      = $signed({9'd0, f_slen});
                allow_nxt     = $signed({9'd0, f_slen});
                off_nxt       = '0;
                active_nxt    = 1'b1;
                pend_nxt      = 1'b0;
                state_nxt     = ST_END;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_CFG: begin
        emit_v = emit_ok;
        e_kind = note_kind_r;
        e_ep   = note_ep_r;
        e_num  = note_num_r;
        if (emit_ok) begin
          state_nxt = ST_END;
        end
      end

      ST_END: begin
        emit_v = emit_ok;
        e_kind = RES_ENDED;
        e_ep   = end_ep_r;
        e_st   = end_st_r;
        e_last = end_last_r;
        if (emit_ok) begin
          if (end_again_r) begin
            end_again_nxt = 1'b0;
            end_st_nxt    = 1'b0;
            end_last_nxt  = 1'b1;
          end else if (end_build_r) begin
            state_nxt = ST_BUILD;
          end else if (start_r) begin
            state_nxt = ST_NOTE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_BUILD: begin
        crc_init = 1'b1;
        cnt_nxt  = '0;
        pend_nxt = 1'b1;
        if (left_r == 0 || allow_r == 0) begin
          if (snd_ep_r != 4'd0) begin
            left_nxt      = '0;
            allow_nxt     = '0;
            off_nxt       = '0;
            active_nxt    = 1'b0;
            pend_nxt      = 1'b0;
            end_ep_nxt    = snd_ep_r;
            end_st_nxt    = 1'b0;
            end_last_nxt  = !start_r;
            end_build_nxt = 1'b0;
            state_nxt     = ST_END;
          end else begin
            // Zero-length packet: the inverted initial CRC is all zeros.
            plen_nxt  = '0;
            state_nxt = ST_CRC_LO;
          end
        end else begin
          plen_nxt  = n_pkt;
          state_nxt = ST_DATA;
        end
      end

      ST_DATA: begin
        emit_v = emit_ok;
        e_byte = rd_q;
        if (emit_ok) begin
          crc_en  = 1'b1;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r + 4'd1 == plen_r) begin
            state_nxt = ST_CRC_LO;
          end
        end
      end

      ST_CRC_LO: begin
        emit_v = emit_ok;
        e_byte = ~crc[7:0];
        if (emit_ok) begin
          state_nxt = ST_CRC_HI;
        end
      end

      ST_CRC_HI: begin
        emit_v = emit_ok;
        e_byte = ~crc[15:8];
        if (emit_ok) begin
          state_nxt = ST_PID;
        end
      end

      ST_PID: begin
        emit_v = emit_ok;
        e_byte = tok_hit ? PID_DATA1 : PID_DATA0;
        e_last = !start_r;
        if (emit_ok) begin
          state_nxt = start_r ? ST_NOTE : ST_IDLE;
        end
      end

      ST_NOTE: begin
        emit_v = emit_ok;
        e_kind = note_kind_r;
        e_ep   = note_ep_r;
        e_num  = note_num_r;
        e_last = 1'b1;
        if (emit_ok) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The read address follows the next byte count, so rd_q always holds
  // the byte at the current count.
  assign rd_addr = AW'(off_r + {12'd0, cnt_nxt});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(f_bidx)] <= f_byte;
    end
    rd_q <= mem[rd_addr];
  end

  usbtx_crc u_crc (
    .clk  (clk),
    .init (crc_init),
    .en   (crc_en),
    .data (rd_q),
    .crc  (crc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_NONE;
      tog_r       <= '0;
      tok_ep_r    <= '0;
      snd_ep_r    <= '0;
      addr_r      <= '0;
      left_r      <= '0;
      allow_r     <= '0;
      off_r       <= '0;
      active_r    <= 1'b0;
      pend_r      <= 1'b0;
      start_r     <= 1'b0;
      end_again_r <= 1'b0;
      end_build_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      tog_r       <= tog_nxt;
      tok_ep_r    <= tok_ep_nxt;
      snd_ep_r    <= snd_ep_nxt;
      addr_r      <= addr_nxt;
      left_r      <= left_nxt;
      allow_r     <= allow_nxt;
      off_r       <= off_nxt;
      active_r    <= active_nxt;
      pend_r      <= pend_nxt;
      start_r     <= start_nxt;
      end_again_r <= end_again_nxt;
      end_build_r <= end_build_nxt;
      if (emit_v) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_ep_r    <= end_ep_nxt;
    end_st_r    <= end_st_nxt;
    end_last_r  <= end_last_nxt;
    note_kind_r <= note_kind_nxt;
    note_ep_r   <= note_ep_nxt;
    note_num_r  <= note_num_nxt;
    cnt_r       <= cnt_nxt;
    plen_r      <= plen_nxt;
    if (emit_v) begin
      out_data_r <= {3'd0, e_num, e_st, e_ep, e_byte};
      out_user_r <= e_kind;
      out_last_r <= e_last;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
